### hdl/unsigned_to_digit_string_macros.svh
// Assertion macros for the digit string converter checkers.
// Needs signals named clk and arst_n in the scope where a macro is used.
`ifndef UNSIGNED_TO_DIGIT_STRING_MACROS_SVH
`define UNSIGNED_TO_DIGIT_STRING_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low
`define UTDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low
`define UTDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/utds_pkg.sv
// Shared constants, digit table and microcode for the digit string converter.
// No dependencies; compiled before the interfaces and all modules.
package utds_pkg;

	localparam int VALUE_W        = 64;
	localparam int VALUE_BITS_DEF = 64;
	localparam int RADIX_W        = 5;
	localparam int CHAR_W         = 7;
	localparam int DIGIT_W        = 4;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

	// Sequencer steps
	typedef enum logic [2:0] {
		ST_FETCH,
		ST_ASCEND,
		ST_DIVIDE,
		ST_EMIT,
		ST_UNWIND,
		ST_RELOAD
	} step_t;

	// Branch conditions
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_FITS,
		C_GE,
		C_OUT_FREE,
		C_EMPTY
	} cond_t;

	// Datapath operations
	typedef enum logic [2:0] {
		U_NOP,
		U_LOAD,
		U_PUSH,
		U_SUB,
		U_EMIT,
		U_POP,
		U_RELOAD
	} uop_t;

	// One control word: op and next step for the taken and not-taken cases
	typedef struct packed {
		logic  in_rdy;
		cond_t cond;
		uop_t  op_t;
		uop_t  op_f;
		step_t nxt_t;
		step_t nxt_f;
	} ucode_t;

	// Microcode ROM
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			ST_FETCH:  w = '{1'b1, C_IN_VALID, U_LOAD,   U_NOP, ST_ASCEND, ST_FETCH};
			ST_ASCEND: w = '{1'b0, C_FITS,     U_PUSH,   U_NOP, ST_ASCEND, ST_DIVIDE};
			ST_DIVIDE: w = '{1'b0, C_GE,       U_SUB,    U_NOP, ST_DIVIDE, ST_EMIT};
			ST_EMIT:   w = '{1'b0, C_OUT_FREE, U_EMIT,   U_NOP, ST_UNWIND, ST_EMIT};
			ST_UNWIND: w = '{1'b0, C_EMPTY,    U_NOP,    U_POP, ST_FETCH,  ST_RELOAD};
			ST_RELOAD: w = '{1'b0, C_ALWAYS,   U_RELOAD, U_NOP, ST_DIVIDE, ST_DIVIDE};
			default:   w = '{1'b0, C_ALWAYS,   U_NOP,    U_NOP, ST_FETCH,  ST_FETCH};
		endcase
		return w;
	endfunction

	// Digit value to lower-case ASCII
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		unique case (d)
			4'h0: c = 7'h30;
			4'h1: c = 7'h31;
			4'h2: c = 7'h32;
			4'h3: c = 7'h33;
			4'h4: c = 7'h34;
			4'h5: c = 7'h35;
			4'h6: c = 7'h36;
			4'h7: c = 7'h37;
			4'h8: c = 7'h38;
			4'h9: c = 7'h39;
			4'ha: c = 7'h61;
			4'hb: c = 7'h62;
			4'hc: c = 7'h63;
			4'hd: c = 7'h64;
			4'he: c = 7'h65;
			4'hf: c = 7'h66;
			default: c = 7'h30;
		endcase
		return c;
	endfunction

endpackage

### hdl/utds_ifs.sv
// Valid/ready stream interfaces for the digit string converter.
// Depends on utds_pkg for payload widths.
interface utds_in_if;
	logic                         valid;
	logic                         ready;
	logic [utds_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface utds_out_if;
	logic                        valid;
	logic                        ready;
	logic [utds_pkg::CHAR_W-1:0] char_code;
	logic                        last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

### hdl/unsigned_to_digit_string.sv
// Unsigned binary to ASCII digit string converter, top level.
// Depends on utds_pkg and the stream interfaces in utds_ifs.sv.
//
// Takes one unsigned value per request on in_ch and returns its digits on
// out_ch as ASCII characters, most significant first, in the base held in the
// radix register (values below 2 act as 2, above 16 as 16); last_char marks
// the final character. One value is converted at a time: in_ch.ready is high
// only while the sequencer waits for a new value. The divide step takes each
// digit by repeated compare and subtract of the place value (one per cycle),
// and the powers of the base are pushed into and popped from a small stack
// memory with a registered read. The last character may wait in the output
// register while the next value is already accepted. Write the radix only
// while idle.
module unsigned_to_digit_string #(
	parameter int VALUE_BITS = utds_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [utds_pkg::RADIX_W-1:0]  cfg_data,
	utds_in_if.sink                       in_ch,
	utds_out_if.source                    out_ch
);
	import utds_pkg::*;

	localparam int SP_W   = $clog2(VALUE_BITS);
	localparam int DEPTH  = VALUE_BITS;
	localparam int PROD_W = VALUE_BITS + RADIX_W;

	logic [RADIX_W-1:0]    radix_q;
	step_t                 step_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] pv_q;
	logic [DIGIT_W-1:0]    digit_q;
	logic [SP_W-1:0]       sp_q;
	logic [VALUE_BITS-1:0] rd_data_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] pow_mem [DEPTH];

	logic [RADIX_W-1:0]    base;
	logic [PROD_W-1:0]     prod;
	logic                  fits;
	logic                  ge;
	logic                  out_free;
	logic                  empty;
	ucode_t                uw;
	logic                  hit;
	uop_t                  op;
	step_t                 step_d;

	// Effective base
	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	// Datapath conditions
	assign prod     = PROD_W'(pv_q) * PROD_W'(base);
	assign fits     = prod <= PROD_W'(rem_q);
	assign ge       = rem_q >= pv_q;
	assign out_free = !out_valid_q || out_ch.ready;
	assign empty    = sp_q == '0;

	// Control word decode and branch
	always_comb begin
		uw = ucode_rom(step_q);
		unique case (uw.cond)
			C_ALWAYS:   hit = 1'b1;
			C_IN_VALID: hit = in_ch.valid;
			C_FITS:     hit = fits;
			C_GE:       hit = ge;
			C_OUT_FREE: hit = out_free;
			C_EMPTY:    hit = empty;
			default:    hit = 1'b0;
		endcase
		op     = hit ? uw.op_t : uw.op_f;
		step_d = hit ? uw.nxt_t : uw.nxt_f;
	end

	assign in_ch.ready      = uw.in_rdy;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.char_code = char_q;
	assign out_ch.last_char = last_q;

	// Control state: step counter, stack pointer, radix, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			step_q      <= ST_FETCH;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_data;
			end
			step_q <= step_d;
			unique case (op)
				U_LOAD:  sp_q <= '0;
				U_PUSH:  sp_q <= sp_q + 1'b1;
				U_POP:   sp_q <= sp_q - 1'b1;
				default: sp_q <= sp_q;
			endcase
			if (op == U_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			pv_q    <= '0;
			digit_q <= '0;
			char_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (op)
				U_LOAD: begin
					rem_q   <= in_ch.value[VALUE_BITS-1:0];
					pv_q    <= VALUE_BITS'(1);
					digit_q <= '0;
				end
				U_PUSH: begin
					pv_q <= prod[VALUE_BITS-1:0];
				end
				U_SUB: begin
					rem_q   <= rem_q - pv_q;
					digit_q <= digit_q + 1'b1;
				end
				U_EMIT: begin
					char_q <= digit_char(digit_q);
					last_q <= empty;
				end
				U_POP: begin
					digit_q <= '0;
				end
				U_RELOAD: begin
					pv_q <= rd_data_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Stack of powers of the base, registered read
	always_ff @(posedge clk) begin
		if (op == U_PUSH) begin
			pow_mem[sp_q] <= pv_q;
		end
		if (op == U_POP) begin
			rd_data_q <= pow_mem[sp_q - 1'b1];
		end
	end

endmodule

### hdl/utds_checker.sv
// Port-level checks for the digit string converter, bound to the top level.
// Depends on unsigned_to_digit_string_macros.svh and utds_pkg.
`include "unsigned_to_digit_string_macros.svh"

module utds_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [utds_pkg::CHAR_W-1:0] char_code,
	input logic                        last_char
);
	import utds_pkg::*;

	// A stalled character holds
	`UTDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_code) && $stable(last_char), "output character changed while stalled")

	// Only digit and lower-case letter codes come out
	`UTDS_ASSERT_NOW(a_char_legal, out_valid, (char_code >= 7'h30 && char_code <= 7'h39) || (char_code >= 7'h61 && char_code <= 7'h66), "illegal character code")

	// No new value is taken while a number is still being sent
	`UTDS_ASSERT_NOW(a_no_accept_mid, out_valid && !last_char, !in_ready, "input ready in the middle of a number")

	// A taken value keeps the input closed for the next cycle
	`UTDS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input ready right after a request")

endmodule

bind unsigned_to_digit_string utds_checker u_utds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.char_code (out_ch.char_code),
	.last_char (out_ch.last_char)
);

### verif/unsigned_to_digit_string_test.sv
// Self-checking testbench for the unsigned to digit string converter.
// Needs utds_pkg, the stream interfaces in utds_ifs.sv and the converter RTL.
module unsigned_to_digit_string_test;
	import utds_pkg::*;

	localparam int HALF_PERIOD      = 6;
	localparam int RESET_CYCLES     = 10;
	localparam int VALUE_BITS       = VALUE_BITS_DEF;
	localparam int RANDOM_PER_PHASE = 25;
	localparam int SWEEP_LEN        = 12;
	localparam int HOLD_PHASE       = 2;
	localparam int HOLD_CYCLES      = 1500;
	localparam int SETTLE_CYCLES    = 8;
	localparam int TAIL_CYCLES      = 400;
	localparam int MAX_SHOWN        = 10;
	localparam longint CYCLE_LIMIT  = 1500000;

	localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);
	localparam logic [VALUE_W-1:0] ALL_ONES   = '1;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h61;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
	} char_rec_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [RADIX_W-1:0] cfg_data;

	utds_in_if  in_ch();
	utds_out_if out_ch();

	unsigned_to_digit_string #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	logic [VALUE_W-1:0] pending_values[$];
	char_rec_t          expected_chars[$];
	logic [RADIX_W-1:0] radix_now;
	bit                 hold_armed;
	bit                 quiet;
	int                 mismatches = 0;
	int                 send_gap;
	int                 recv_stall;
	int                 hold_left;
	bit                 hold_done;
	longint             cycle_count = 0;

	always #HALF_PERIOD clk = ~clk;

	// Digits of one value, most significant first, as the converter should emit them
	function automatic void predict_digits(input logic [VALUE_W-1:0] raw,
			input logic [RADIX_W-1:0] reg_radix);
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] rest;
		logic [VALUE_W-1:0] place;
		logic [VALUE_W-1:0] digit;
		char_rec_t          rec;
		if (reg_radix < RADIX_MIN) begin
			base = VALUE_W'(RADIX_MIN);
		end else if (reg_radix > RADIX_MAX) begin
			base = VALUE_W'(RADIX_MAX);
		end else begin
			base = VALUE_W'(reg_radix);
		end
		rest  = raw & VALUE_MASK;
		place = 1;
		// climb only while the next power stays at or below the value
		while (rest / place >= base)
			place = place * base;
		while (place != 0) begin
			digit = rest / place;
			rest  = rest % place;
			place = place / base;
			if (digit < 10)
				rec.char_code = CHAR_ZERO + CHAR_W'(digit);
			else
				rec.char_code = CHAR_A + CHAR_W'(digit - 10);
			rec.last_char = (place == 0);
			expected_chars.push_back(rec);
		end
	endfunction

	// Mix of short, near-full, single-bit and random-width values
	function automatic logic [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = VALUE_W'($urandom_range(0, 40));
			1: v = ALL_ONES - VALUE_W'($urandom_range(0, 40));
			2: v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
			default: v = v >> $urandom_range(0, VALUE_W - 1);
		endcase
		return v;
	endfunction

	// Wait until every request is taken and every character has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_values.size() != 0 || in_ch.valid || expected_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Radix write, only with the converter idle
	task automatic set_radix(input logic [RADIX_W-1:0] r);
		wait_drained();
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		radix_now = r;
	endtask

	// Request driver: holds a request until taken, random gaps between requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.value <= '0;
			send_gap    <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap != 0) begin
				in_ch.valid <= 1'b0;
				send_gap    <= send_gap - 1;
			end else if (pending_values.size() != 0) begin
				in_ch.valid <= 1'b1;
				in_ch.value <= pending_values.pop_front();
				if (!quiet && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 10);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Character receiver: one long hold-off, otherwise random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_stall   <= 0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
		end else if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (hold_armed && !hold_done) begin
			out_ch.ready <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			hold_done    <= 1'b1;
		end else if (recv_stall != 0) begin
			out_ch.ready <= 1'b0;
			recv_stall   <= recv_stall - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_ch.ready <= 1'b0;
			recv_stall   <= $urandom_range(0, 9);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Check taken characters against the oldest prediction, then predict new requests
	always @(posedge clk) begin
		char_rec_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected char: code %0h last %0b",
							out_ch.char_code, out_ch.last_char);
				end else begin
					want = expected_chars.pop_front();
					if (out_ch.char_code !== want.char_code ||
							out_ch.last_char !== want.last_char) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("char mismatch: expected code %0h last %0b, got code %0h last %0b",
								want.char_code, want.last_char,
								out_ch.char_code, out_ch.last_char);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_digits(in_ch.value, radix_now);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("unsigned_to_digit_string_test failed");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		logic [RADIX_W-1:0] sweep [SWEEP_LEN];
		sweep = '{5'd10, 5'd2, 5'd16, 5'd5, 5'd31, 5'd0, 5'd12, 5'd3, 5'd17, 5'd1, 5'd8,
			RADIX_W'($urandom_range(0, 31))};
		cfg_we       = 1'b0;
		cfg_data     = RADIX_RESET;
		hold_armed   = 1'b0;
		quiet        = 1'b0;
		radix_now    = RADIX_RESET;
		arst_n       = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// decimal at the reset radix: single digits, digit roll-over, largest values
		pending_values.push_back(64'd0);
		pending_values.push_back(64'd9);
		pending_values.push_back(64'd10);
		pending_values.push_back(64'd99);
		pending_values.push_back(64'd10000000000000000000);
		pending_values.push_back(ALL_ONES);

		// binary: longest strings
		set_radix(5'd2);
		pending_values.push_back(64'd0);
		pending_values.push_back(64'd1);
		pending_values.push_back(64'd2);
		pending_values.push_back(ALL_ONES);
		pending_values.push_back(64'h8000_0000_0000_0000);

		// hex: every letter digit, top place value
		set_radix(5'd16);
		pending_values.push_back(64'd15);
		pending_values.push_back(64'd16);
		pending_values.push_back(64'h0123_4567_89ab_cdef);
		pending_values.push_back(64'hf000_0000_0000_0000);
		pending_values.push_back(ALL_ONES);

		// radix register below two acts as binary
		set_radix(5'd0);
		pending_values.push_back(64'd3);
		set_radix(5'd1);
		pending_values.push_back(64'd255);

		// radix register above sixteen acts as hex
		set_radix(5'd17);
		pending_values.push_back(64'hfedc_ba98_7654_3210);
		set_radix(5'd31);
		pending_values.push_back(64'd31);

		// odd bases where the next power would overflow 64 bits
		set_radix(5'd3);
		pending_values.push_back(64'd12157665459056928801);
		pending_values.push_back(ALL_ONES);
		set_radix(5'd7);
		pending_values.push_back(ALL_ONES);

		// random phases across the radix sweep
		for (int p = 0; p < SWEEP_LEN; p++) begin
			set_radix(sweep[p]);
			if (p == HOLD_PHASE)
				hold_armed = 1'b1;
			if (p == SWEEP_LEN - 1)
				quiet = 1'b1;
			repeat (RANDOM_PER_PHASE) pending_values.push_back(random_value());
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("unsigned_to_digit_string_test passed");
		else
			$display("unsigned_to_digit_string_test failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/utds_pkg.sv
hdl/utds_ifs.sv
hdl/unsigned_to_digit_string.sv
hdl/utds_checker.sv
verif/unsigned_to_digit_string_test.sv
